@@ rtl/core/rgb2ycc_pkg.sv @@
package rgb2ycc_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int HALF_DEPTH   = MAX_WIDTH / 2;
	localparam int SLOT_W       = $clog2(HALF_DEPTH);
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int SIZE_W       = 13;
	localparam int SUM_W        = 10;
	localparam int CHROMA_W     = 12;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);
	localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(HEIGHT_LIMIT);

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic signed [CHROMA_W-1:0] CHROMA_BIAS = CHROMA_W'(1024);

	typedef struct packed {
		logic              in_area;
		logic              col_odd;
		logic              row_odd;
		logic              frame_end;
		logic [SLOT_W-1:0] slot;
	} pos_t;

endpackage

@@ rtl/core/rgb2ycc_ram.sv @@
module rgb2ycc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/rgb2ycc_pos.sv @@
module rgb2ycc_pos (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_index,
	input  logic [rgb2ycc_pkg::SIZE_W-1:0]   cfg_data,
	input  logic                             advance,
	output rgb2ycc_pkg::pos_t                pos
);
	import rgb2ycc_pkg::*;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [SIZE_W-1:0] col_next;
	logic [SIZE_W-1:0] row_next;
	logic              row_end;
	logic              frame_end;

	always_comb begin
		if (width_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (height_q > HEIGHT_MAX) begin
			h_eff = HEIGHT_MAX;
		end else begin
			h_eff = height_q;
		end
		col_next  = SIZE_W'(col_q) + SIZE_W'(1);
		row_next  = SIZE_W'(row_q) + SIZE_W'(1);
		row_end   = col_next >= w_eff;
		frame_end = row_end && (row_next >= h_eff);
	end

	assign pos.in_area   = (SIZE_W'(col_q) < {w_eff[SIZE_W-1:1], 1'b0})
		&& (SIZE_W'(row_q) < {h_eff[SIZE_W-1:1], 1'b0});
	assign pos.col_odd   = col_q[0];
	assign pos.row_odd   = row_q[0];
	assign pos.frame_end = frame_end;
	assign pos.slot      = col_q[COL_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

@@ rtl/core/rgb2ycc_xform.sv @@
module rgb2ycc_xform (
	input  logic              [7:0] red,
	input  logic              [7:0] green,
	input  logic              [7:0] blue,
	output logic signed       [8:0] co,
	output logic signed       [8:0] cg,
	output logic              [7:0] luma
);

	logic signed [8:0] co_half;
	logic signed [8:0] cg_half;
	logic        [7:0] t;

	always_comb begin
		co      = $signed({1'b0, red}) - $signed({1'b0, blue});
		co_half = co >>> 1;
		t       = blue + co_half[7:0];
		cg      = $signed({1'b0, green}) - $signed({1'b0, t});
		cg_half = cg >>> 1;
		luma    = t + cg_half[7:0];
	end

endmodule

@@ rtl/core/rgb_to_ycocgr420_stream.sv @@
// Pipeline: an accepted beat is registered in s1, then in s2.
// Throughput: one pixel per cycle unless out_ready stalls s2; the line
// store reads one entry per accepted beat, writes even-row pair sums.
// Reset: asynchronous, active low; clears the position counters, pair sums
// and handshake state, and loads the frame size 1920 x 1080.
module rgb_to_ycocgr420_stream (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [rgb2ycc_pkg::SIZE_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     luma,
	output logic                           inside_res,
	output logic [7:0]                     co_avg,
	output logic [7:0]                     cg_avg,
	output logic                           chroma_valid,
	output logic                           frame_end
);
	import rgb2ycc_pkg::*;

	pos_t                       pos;
	pos_t                       pos_s1;
	logic                       valid_s1;
	logic [7:0]                 red_s1;
	logic [7:0]                 green_s1;
	logic [7:0]                 blue_s1;
	logic                       in_acc;
	logic                       s2_load;
	logic                       s1_adv;

	logic signed [8:0]          co;
	logic signed [8:0]          cg;
	logic [7:0]                 y;
	logic signed [SUM_W-1:0]    pair_co_q;
	logic signed [SUM_W-1:0]    pair_cg_q;
	logic signed [SUM_W-1:0]    pair_co_nx;
	logic signed [SUM_W-1:0]    pair_cg_nx;
	logic [2*SUM_W-1:0]         line_rd;
	logic signed [CHROMA_W-1:0] co_sum;
	logic signed [CHROMA_W-1:0] cg_sum;
	logic                       line_wr;
	logic                       chroma;

	logic                       valid_s2;
	logic [7:0]                 luma_s2;
	logic                       in_area_s2;
	logic [7:0]                 co_avg_s2;
	logic [7:0]                 cg_avg_s2;
	logic                       chroma_s2;
	logic                       frame_end_s2;

	assign cfg_ready = 1'b1;
	assign s2_load   = !valid_s2 || out_ready;
	assign s1_adv    = valid_s1 && s2_load;
	assign in_ready  = !valid_s1 || s2_load;
	assign in_acc    = in_valid && in_ready;

	rgb2ycc_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_acc),
		.pos       (pos)
	);

	rgb2ycc_xform u_xform (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.co    (co),
		.cg    (cg),
		.luma  (y)
	);

	rgb2ycc_ram #(
		.WIDTH (2 * SUM_W),
		.DEPTH (HALF_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (pos_s1.slot),
		.wr_data ({pair_co_nx, pair_cg_nx}),
		.rd_en   (in_acc),
		.rd_addr (pos.slot),
		.rd_data (line_rd)
	);

	always_comb begin
		if (pos_s1.col_odd) begin
			pair_co_nx = pair_co_q + SUM_W'(co);
			pair_cg_nx = pair_cg_q + SUM_W'(cg);
		end else begin
			pair_co_nx = SUM_W'(co);
			pair_cg_nx = SUM_W'(cg);
		end
		line_wr = s1_adv && pos_s1.in_area && pos_s1.col_odd && !pos_s1.row_odd;
		chroma  = pos_s1.in_area && pos_s1.col_odd && pos_s1.row_odd;
		co_sum  = CHROMA_W'($signed(line_rd[2*SUM_W-1:SUM_W])) + CHROMA_W'(pair_co_nx)
			+ CHROMA_BIAS;
		cg_sum  = CHROMA_W'($signed(line_rd[SUM_W-1:0])) + CHROMA_W'(pair_cg_nx)
			+ CHROMA_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			pos_s1   <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_co_q <= '0;
			pair_cg_q <= '0;
		end else if (s1_adv && pos_s1.in_area) begin
			pair_co_q <= pair_co_nx;
			pair_cg_q <= pair_cg_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			luma_s2      <= pos_s1.in_area ? y : 8'd0;
			in_area_s2   <= pos_s1.in_area;
			co_avg_s2    <= chroma ? co_sum[10:3] : 8'd0;
			cg_avg_s2    <= chroma ? cg_sum[10:3] : 8'd0;
			chroma_s2    <= chroma;
			frame_end_s2 <= pos_s1.frame_end;
		end
	end

	assign out_valid    = valid_s2;
	assign luma         = luma_s2;
	assign inside_res   = in_area_s2;
	assign co_avg       = co_avg_s2;
	assign cg_avg       = cg_avg_s2;
	assign chroma_valid = chroma_s2;
	assign frame_end    = frame_end_s2;

endmodule

@@ tb/ycocg_stream_checker.sv @@
module ycocg_stream_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [rgb2ycc_pkg::SIZE_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [7:0]                     luma,
	input  logic                           inside_res,
	input  logic [7:0]                     co_avg,
	input  logic [7:0]                     cg_avg,
	input  logic                           chroma_valid,
	input  logic                           frame_end,
	output int                             failures,
	output int                             pending
);
	import rgb2ycc_pkg::*;

	typedef struct {
		logic [7:0] luma;
		logic       in_area;
		logic [7:0] co;
		logic [7:0] cg;
		logic       chroma;
		logic       frame_last;
	} pixel_result_t;

	pixel_result_t     expected_pixels[$];
	logic [SIZE_W-1:0] width_reg  = WIDTH_RESET;
	logic [SIZE_W-1:0] height_reg = HEIGHT_RESET;
	int                col_pos;
	int                row_pos;
	int                pair_co;
	int                pair_cg;
	int                line_co[HALF_DEPTH];
	int                line_cg[HALF_DEPTH];
	int                result_beat;

	function automatic int clamp_size(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] limit);
		if (v == '0)
			return 1;
		return (v > limit) ? int'(limit) : int'(v);
	endfunction

	task automatic report_mismatch(input string what);
		$display("beat %0d: %s", result_beat, what);
		failures++;
	endtask

	task automatic transform_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		pixel_result_t res;
		int co, t, cg, y, w, h, slot, sco, scg;
		bit row_end;
		co = int'(r) - int'(b);
		t = int'(b) + (co >>> 1);
		cg = int'(g) - t;
		y = t + (cg >>> 1);
		w = clamp_size(width_reg, WIDTH_MAX);
		h = clamp_size(height_reg, HEIGHT_MAX);
		res.luma = '0;
		res.co = '0;
		res.cg = '0;
		res.chroma = 1'b0;
		res.in_area = (col_pos < (w & ~1)) && (row_pos < (h & ~1));
		if (res.in_area) begin
			slot = (col_pos >> 1) % HALF_DEPTH;
			res.luma = y[7:0];
			if ((col_pos & 1) == 0) begin
				pair_co = co;
				pair_cg = cg;
			end else begin
				pair_co += co;
				pair_cg += cg;
				if ((row_pos & 1) == 0) begin
					line_co[slot] = pair_co;
					line_cg[slot] = pair_cg;
				end else begin
					sco = line_co[slot] + pair_co + 1024;
					scg = line_cg[slot] + pair_cg + 1024;
					if (sco < 0)
						sco = 0;
					if (scg < 0)
						scg = 0;
					res.co = 8'(sco >> 3);
					res.cg = 8'(scg >> 3);
					res.chroma = 1'b1;
				end
			end
		end
		row_end = (col_pos + 1) >= w;
		res.frame_last = row_end && ((row_pos + 1) >= h);
		if (row_end) begin
			col_pos = 0;
			row_pos = res.frame_last ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		expected_pixels.push_back(res);
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (in_valid && in_ready)
				transform_pixel(red, green, blue);
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_pixels.pop_front();
					if (luma !== want.luma)
						report_mismatch($sformatf("luma %0d, expected %0d", luma, want.luma));
					if (inside_res !== want.in_area)
						report_mismatch($sformatf("inside_res %0b, expected %0b",
							inside_res, want.in_area));
					if (co_avg !== want.co)
						report_mismatch($sformatf("co_avg %0d, expected %0d", co_avg, want.co));
					if (cg_avg !== want.cg)
						report_mismatch($sformatf("cg_avg %0d, expected %0d", cg_avg, want.cg));
					if (chroma_valid !== want.chroma)
						report_mismatch($sformatf("chroma_valid %0b, expected %0b",
							chroma_valid, want.chroma));
					if (frame_end !== want.frame_last)
						report_mismatch($sformatf("frame_end %0b, expected %0b",
							frame_end, want.frame_last));
				end
				result_beat++;
			end
			pending = expected_pixels.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
module testbench;
	import rgb2ycc_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_PIXELS = 110;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_index = REG_FRAME_WIDTH;
	logic [SIZE_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic [7:0]        red       = '0;
	logic [7:0]        green     = '0;
	logic [7:0]        blue      = '0;
	logic              out_ready = 1'b0;
	logic              cfg_ready;
	logic              in_ready;
	logic              out_valid;
	logic [7:0]        luma;
	logic              inside_res;
	logic [7:0]        co_avg;
	logic [7:0]        cg_avg;
	logic              chroma_valid;
	logic              frame_end;
	int                failures;
	int                pending;
	int unsigned       send_idle = 0;
	int unsigned       recv_idle = 0;
	bit                hold_arm  = 1'b0;
	int unsigned       hold_count = 0;
	int unsigned       pixels_sent = 0;

	rgb_to_ycocgr420_stream DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.luma         (luma),
		.inside_res   (inside_res),
		.co_avg       (co_avg),
		.cg_avg       (cg_avg),
		.chroma_valid (chroma_valid),
		.frame_end    (frame_end)
	);

	ycocg_stream_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.luma         (luma),
		.inside_res   (inside_res),
		.co_avg       (co_avg),
		.cg_avg       (cg_avg),
		.chroma_valid (chroma_valid),
		.frame_end    (frame_end),
		.failures     (failures),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// hold the output off for one long stretch once armed, else stall at random
	always @(posedge clk) begin
		if (hold_arm && hold_count < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		#5_000_000;
		$display("[rgb_to_ycocgr420_stream] ERROR");
		$finish;
	end

	task automatic send_pixel(input logic [23:0] rgb);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red <= rgb[23:16];
		green <= rgb[15:8];
		blue <= rgb[7:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	function automatic logic [7:0] random_level();
		if ($urandom_range(3) != 0)
			return 8'($urandom_range(255));
		return $urandom_range(1) ? 8'hFF : 8'h00;
	endfunction

	task automatic send_random_pixels(input int count);
		repeat (count)
			send_pixel({random_level(), random_level(), random_level()});
	endtask

	task automatic send_block(input logic [23:0] rgb, input int count);
		repeat (count)
			send_pixel(rgb);
	endtask

	// drop valid, then wait for every outstanding pixel to come out
	task automatic drain_stream();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
			input bit with_hold);
		int unsigned start;
		int w, h;
		send_idle = s_idle;
		recv_idle <= r_idle;
		if (with_hold) begin
			set_frame(SIZE_W'(16), SIZE_W'(4));
			hold_arm <= 1'b1;
			send_random_pixels(64);
			drain_stream();
		end
		start = pixels_sent;
		while (pixels_sent - start < PHASE_PIXELS) begin
			w = $urandom_range(12);
			h = $urandom_range(8);
			set_frame(SIZE_W'(w), SIZE_W'(h));
			send_random_pixels($urandom_range(1, 2) * (w == 0 ? 1 : w) * (h == 0 ? 1 : h));
			drain_stream();
		end
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two pixels at the reset frame size, then zero sizes wrap the counters
		send_pixel(24'h123456);
		send_pixel(24'hFEDCBA);
		drain_stream();
		set_frame('0, '0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		drain_stream();

		// odd trailing column and row around a block of maximum Cg
		set_frame(SIZE_W'(3), SIZE_W'(3));
		send_block(24'h00FF00, 2);
		send_pixel(24'hFFFFFF);
		send_block(24'h00FF00, 2);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		send_pixel(24'h80807F);
		drain_stream();

		set_frame(SIZE_W'(2), SIZE_W'(2));
		send_block(24'hFF0000, 4);
		send_block(24'h0000FF, 4);
		send_block(24'hFF00FF, 4);
		drain_stream();

		// oversize registers for part of a frame, then zero sizes wrap back to the start
		set_frame('1, SIZE_W'(2));
		send_random_pixels(24);
		drain_stream();
		set_frame('0, '0);
		send_random_pixels(1);
		drain_stream();
		set_frame(SIZE_W'(2), '1);
		send_random_pixels(24);
		drain_stream();
		set_frame('0, '0);
		send_random_pixels(1);
		drain_stream();

		run_phase(29, 74, 1'b1);
		run_phase(74, 29, 1'b0);
		run_phase(0, 0, 1'b0);

		if (failures == 0 && pending == 0)
			$display("[rgb_to_ycocgr420_stream] OK");
		else
			$display("[rgb_to_ycocgr420_stream] ERROR");
		$finish;
	end

endmodule
